/* rtl/core/xfd_pkg.sv */
`timescale 1ns / 1ps

package xfd_pkg;

  // Largest payload a frame may carry
  localparam int MAX_PAYLOAD = 32;
  localparam int STORE_AW    = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int BYTE_W      = 8;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SYNC_FIRST  = 1'b0,
    REG_SYNC_SECOND = 1'b1
  } cfg_reg_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_COMMAND = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  // Readout sequencer states
  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_READ = 2'd1,
    EM_SHOW = 2'd2
  } emit_state_t;

  // Payload store write request
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [BYTE_W-1:0]   data;
  } store_wr_t;

  // Start of a frame readout
  typedef struct packed {
    logic              go;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] cmd;
  } run_start_t;

endpackage

/* rtl/core/xfd_rx_if.sv */
`timescale 1ns / 1ps

interface xfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/xfd_frame_if.sv */
`timescale 1ns / 1ps

interface xfd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] command;
  logic [5:0] frame_length;
  logic       has_data;
  logic [4:0] byte_index;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output command, output frame_length, output has_data,
                  output byte_index, output payload_byte, output last, input ready);
  modport sink   (input valid, input command, input frame_length, input has_data,
                  input byte_index, input payload_byte, input last, output ready);
endinterface

/* rtl/core/xor_frame_deframer.sv */
`timescale 1ns / 1ps

// Byte stream frame parser: sync_first, sync_second, length, command,
// length payload bytes, then an XOR checksum over all of them.
// rx: one received byte per request (valid/ready). frame: one result per
// request, command, frame_length, has_data, byte_index, payload_byte, last.
// Config: cfg_wr_en writes cfg_data into the register at cfg_index
// (0 sync_first, 1 sync_second); write only while no frame is in flight.
// The input takes a byte whenever no readout runs. On a good checksum byte the
// frame is read back from the 32-entry payload store one entry at a time
// (registered read in EM_READ, then output in EM_SHOW); an empty frame gives
// one result with no read. rx.ready stays low for the whole run. A stalled
// receiver holds the current result and the run, and with it the input side.
// Reset: sync registers go to 0xAA / 0x55 and the parser hunts the first
// sync byte; the payload store is not cleared.
module xor_frame_deframer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  xfd_pkg::cfg_reg_t     cfg_index,
  input  logic [7:0]            cfg_data,
  xfd_rx_if.sink                rx,
  xfd_frame_if.source           frame
);

  logic [7:0]                 sync_first;
  logic [7:0]                 sync_second;
  xfd_pkg::phase_t            phase;
  xfd_pkg::phase_t            phase_next;
  logic [xfd_pkg::LEN_W-1:0]  frame_len;
  logic [xfd_pkg::LEN_W-1:0]  frame_len_next;
  logic [xfd_pkg::LEN_W-1:0]  byte_count;
  logic [xfd_pkg::LEN_W-1:0]  byte_count_next;
  logic [xfd_pkg::LEN_W-1:0]  count_inc;
  logic [7:0]                 held_command;
  logic [7:0]                 held_command_next;
  logic [7:0]                 running_check;
  logic [7:0]                 running_check_next;
  logic                       take;
  logic                       busy;
  xfd_pkg::store_wr_t         store_wr;
  xfd_pkg::run_start_t        run_start;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= 8'hAA;
      sync_second <= 8'h55;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        xfd_pkg::REG_SYNC_FIRST:  sync_first  <= cfg_data;
        xfd_pkg::REG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx.ready  = !busy;
  assign take      = rx.valid && rx.ready;
  assign count_inc = byte_count + xfd_pkg::LEN_W'(1);

  // Parser: next phase, header fields, checksum and store write
  always_comb begin
    phase_next         = phase;
    frame_len_next     = frame_len;
    byte_count_next    = byte_count;
    held_command_next  = held_command;
    running_check_next = running_check;
    store_wr.en        = 1'b0;
    store_wr.addr      = byte_count[xfd_pkg::STORE_AW-1:0];
    store_wr.data      = rx.rx_byte;
    run_start.go       = 1'b0;
    run_start.len      = frame_len;
    run_start.cmd      = held_command;
    if (take) begin
      case (phase)
        xfd_pkg::PH_SYNC2: begin
          phase_next = (rx.rx_byte == sync_second) ? xfd_pkg::PH_LENGTH : xfd_pkg::PH_SYNC1;
        end
        xfd_pkg::PH_LENGTH: begin
          if (rx.rx_byte > 8'(xfd_pkg::MAX_PAYLOAD)) begin
            phase_next = xfd_pkg::PH_SYNC1;
          end else begin
            frame_len_next     = rx.rx_byte[xfd_pkg::LEN_W-1:0];
            running_check_next = sync_first ^ sync_second ^ rx.rx_byte;
            byte_count_next    = '0;
            phase_next         = xfd_pkg::PH_COMMAND;
          end
        end
        xfd_pkg::PH_COMMAND: begin
          held_command_next  = rx.rx_byte;
          running_check_next = running_check ^ rx.rx_byte;
          phase_next = (frame_len == '0) ? xfd_pkg::PH_CHECK : xfd_pkg::PH_PAYLOAD;
        end
        xfd_pkg::PH_PAYLOAD: begin
          store_wr.en        = 1'b1;
          byte_count_next    = count_inc;
          running_check_next = running_check ^ rx.rx_byte;
          if (count_inc >= frame_len) begin
            phase_next = xfd_pkg::PH_CHECK;
          end
        end
        xfd_pkg::PH_CHECK: begin
          phase_next   = xfd_pkg::PH_SYNC1;
          run_start.go = (rx.rx_byte == running_check);
        end
        default: begin
          // hunting, also covers the unused codes
          phase_next = (rx.rx_byte == sync_first) ? xfd_pkg::PH_SYNC2 : xfd_pkg::PH_SYNC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= xfd_pkg::PH_SYNC1;
      frame_len     <= '0;
      byte_count    <= '0;
      held_command  <= '0;
      running_check <= '0;
    end else begin
      phase         <= phase_next;
      frame_len     <= frame_len_next;
      byte_count    <= byte_count_next;
      held_command  <= held_command_next;
      running_check <= running_check_next;
    end
  end

  xfd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .store_wr  (store_wr),
    .run_start (run_start),
    .busy      (busy),
    .frame     (frame)
  );

  // A result on the output always blocks new input bytes
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    frame.valid |-> !rx.ready)
    else $error("result shown while input is open");

  // A good checksum byte starts a readout, which closes the input
  a_good_frame_runs: assert property (@(posedge clk) disable iff (rst)
    (take && phase == xfd_pkg::PH_CHECK && rx.rx_byte == running_check) |=> !rx.ready)
    else $error("good frame did not start a readout");

  // Taking the final result reopens the input
  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready && frame.last) |=> rx.ready)
    else $error("input stays closed after the last result");

  // The store is written only while the input is open
  a_write_when_open: assert property (@(posedge clk) disable iff (rst)
    store_wr.en |-> !busy)
    else $error("payload store written during readout");

endmodule

/* rtl/core/xfd_emit.sv */
`timescale 1ns / 1ps

module xfd_emit (
  input  logic                clk,
  input  logic                rst,
  input  xfd_pkg::store_wr_t  store_wr,
  input  xfd_pkg::run_start_t run_start,
  output logic                busy,
  xfd_frame_if.source         frame
);

  logic [xfd_pkg::BYTE_W-1:0]   store [xfd_pkg::MAX_PAYLOAD];
  logic [xfd_pkg::BYTE_W-1:0]   rd_data;
  xfd_pkg::emit_state_t         state;
  xfd_pkg::emit_state_t         state_next;
  logic [xfd_pkg::STORE_AW-1:0] idx;
  logic [xfd_pkg::STORE_AW-1:0] idx_next;
  logic [xfd_pkg::LEN_W-1:0]    len;
  logic [xfd_pkg::BYTE_W-1:0]   cmd;
  logic                         empty;
  logic                         is_last;

  // Payload store: one write port from the parser, one registered read port
  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store[store_wr.addr] <= store_wr.data;
    end
    rd_data <= store[idx];
  end

  assign empty   = (len == '0);
  assign is_last = empty || ((xfd_pkg::LEN_W'(idx) + xfd_pkg::LEN_W'(1)) == len);

  // Sequencer: read one entry, show it, repeat until the last one is taken; an empty frame skips the read
  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      xfd_pkg::EM_IDLE: begin
        if (run_start.go) begin
          idx_next   = '0;
          state_next = (run_start.len == '0) ? xfd_pkg::EM_SHOW : xfd_pkg::EM_READ;
        end
      end
      xfd_pkg::EM_READ: begin
        state_next = xfd_pkg::EM_SHOW;
      end
      xfd_pkg::EM_SHOW: begin
        if (frame.ready) begin
          if (is_last) begin
            state_next = xfd_pkg::EM_IDLE;
          end else begin
            idx_next   = idx + xfd_pkg::STORE_AW'(1);
            state_next = xfd_pkg::EM_READ;
          end
        end
      end
      default: begin
        state_next = xfd_pkg::EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xfd_pkg::EM_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Frame header held for the whole run
  always_ff @(posedge clk) begin
    if (state == xfd_pkg::EM_IDLE && run_start.go) begin
      len <= run_start.len;
      cmd <= run_start.cmd;
    end
  end

  assign busy = (state != xfd_pkg::EM_IDLE);

  // Result outputs
  assign frame.valid        = (state == xfd_pkg::EM_SHOW);
  assign frame.command      = cmd;
  assign frame.frame_length = len;
  assign frame.has_data     = !empty;
  assign frame.byte_index   = idx;
  assign frame.payload_byte = empty ? '0 : rd_data;
  assign frame.last         = is_last;

endmodule
